FILE: rtl/sbeq_pkg.sv
// ----------------------------------------------------------------------------
// sbeq_pkg
// Shared types, constants and arithmetic helpers of the stereo biquad
// equalizer.
// ----------------------------------------------------------------------------
package sbeq_pkg;

  localparam int unsigned DEF_BAND_COUNT = 16;
  localparam int unsigned SAMPLE_W       = 24;
  localparam int unsigned COEF_W         = 32;
  localparam int unsigned STATE_W        = 40;
  localparam int unsigned GUARD_W        = 8;
  localparam int unsigned COEF_FRAC      = COEF_W - 3;
  localparam int unsigned COEF_SLOTS     = 5;
  localparam int unsigned HALF_W         = STATE_W / 2;
  localparam int unsigned OPND_W         = HALF_W + 1;
  localparam int unsigned PROD_W         = COEF_W + OPND_W;
  localparam int unsigned FULL_W         = COEF_W + STATE_W + 1;
  localparam int unsigned RND_W          = FULL_W - COEF_FRAC;
  localparam int unsigned ACC_W          = RND_W + 2;
  localparam int unsigned FIN_W          = STATE_W + 1 - GUARD_W;
  localparam int unsigned STEP_W         = 4;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(12);

  localparam logic [1:0] ACT_FILTER = 2'd0;
  localparam logic [1:0] ACT_LOAD   = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  localparam logic [2:0] COEF_B0 = 3'd0;
  localparam logic [2:0] COEF_B1 = 3'd1;
  localparam logic [2:0] COEF_B2 = 3'd2;
  localparam logic [2:0] COEF_A1 = 3'd3;
  localparam logic [2:0] COEF_A2 = 3'd4;

  localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_Y,
    ACC_S1,
    ACC_S2,
    ACC_S1F,
    ACC_WB
  } acc_op_e;

  typedef struct packed {
    logic       start;
    logic       coef_wr;
    logic       clear;
    logic       coef_rd;
    logic [2:0] coef_idx;
    logic       dly_rd;
    logic       mul_hi;
    logic       mul_y;
    acc_op_e    acc;
    logic       chan_sw;
    logic       out_load;
  } cmd_t;

  function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [ACC_W-1:0] v);
    logic signed [STATE_W-1:0] r;
    if (v[ACC_W-1:STATE_W-1] == {(ACC_W-STATE_W+1){v[STATE_W-1]}}) begin
      r = v[STATE_W-1:0];
    end else if (v[ACC_W-1]) begin
      r = {1'b1, {(STATE_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(STATE_W-1){1'b1}}};
    end
    return r;
  endfunction

  // round half up by the guard bits, then saturate to the sample width
  function automatic logic signed [SAMPLE_W-1:0] finish_sample(
    input logic signed [STATE_W-1:0] v
  );
    logic signed [STATE_W:0]    t;
    logic signed [FIN_W-1:0]    sh;
    logic signed [SAMPLE_W-1:0] r;
    t  = (STATE_W+1)'(v) + (STATE_W+1)'(1 << (GUARD_W - 1));
    sh = t[STATE_W:GUARD_W];
    if (sh[FIN_W-1:SAMPLE_W-1] == {(FIN_W-SAMPLE_W+1){sh[SAMPLE_W-1]}}) begin
      r = sh[SAMPLE_W-1:0];
    end else if (sh[FIN_W-1]) begin
      r = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

FILE: rtl/sbeq_ctrl.sv
// ----------------------------------------------------------------------------
// sbeq_ctrl
// Sequencer: takes words, walks bands and channels step by step and
// drives the datapath commands and the output handshake.
// ----------------------------------------------------------------------------
module sbeq_ctrl #(
  parameter int unsigned BAND_COUNT = sbeq_pkg::DEF_BAND_COUNT,
  parameter int unsigned BAND_W     = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        action_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sbeq_pkg::cmd_t    cmd_o,
  output logic [BAND_W-1:0] band_o,
  output logic              chan_o
);
  import sbeq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FIN
  } state_e;

  state_e              state_q;
  logic [STEP_W-1:0]   step_q;
  logic [BAND_W-1:0]   band_q;
  logic                chan_q;
  logic                out_valid_q;
  logic                accept;
  logic                last_band;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign last_band   = (band_q == BAND_W'(BAND_COUNT - 1));
  assign out_valid_o = out_valid_q;
  assign band_o      = band_q;
  assign chan_o      = chan_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.acc      = ACC_NONE;
    cmd_o.coef_idx = COEF_B0;
    if (accept) begin
      case (action_i)
        ACT_FILTER: cmd_o.start   = 1'b1;
        ACT_LOAD:   cmd_o.coef_wr = 1'b1;
        ACT_CLEAR:  cmd_o.clear   = 1'b1;
        default:    cmd_o.start   = 1'b0;
      endcase
    end
    if (state_q == S_RUN) begin
      case (step_q)
        STEP_W'(0): begin
          cmd_o.coef_rd  = 1'b1;
          cmd_o.coef_idx = COEF_B0;
          cmd_o.dly_rd   = 1'b1;
        end
        STEP_W'(2): begin
          cmd_o.mul_hi   = 1'b1;
          cmd_o.coef_rd  = 1'b1;
          cmd_o.coef_idx = COEF_B1;
        end
        STEP_W'(4): begin
          cmd_o.mul_hi   = 1'b1;
          cmd_o.coef_rd  = 1'b1;
          cmd_o.coef_idx = COEF_B2;
          cmd_o.acc      = ACC_Y;
        end
        STEP_W'(6): begin
          cmd_o.mul_hi   = 1'b1;
          cmd_o.coef_rd  = 1'b1;
          cmd_o.coef_idx = COEF_A1;
          cmd_o.acc      = ACC_S1;
        end
        STEP_W'(7): begin
          cmd_o.mul_y = 1'b1;
        end
        STEP_W'(8): begin
          cmd_o.mul_y    = 1'b1;
          cmd_o.mul_hi   = 1'b1;
          cmd_o.coef_rd  = 1'b1;
          cmd_o.coef_idx = COEF_A2;
          cmd_o.acc      = ACC_S2;
        end
        STEP_W'(9): begin
          cmd_o.mul_y = 1'b1;
        end
        STEP_W'(10): begin
          cmd_o.mul_y  = 1'b1;
          cmd_o.mul_hi = 1'b1;
          cmd_o.acc    = ACC_S1F;
        end
        STEP_LAST: begin
          cmd_o.acc     = ACC_WB;
          cmd_o.chan_sw = last_band && !chan_q;
        end
        default: cmd_o.mul_hi = 1'b0;
      endcase
    end
    if ((state_q == S_FIN) && (!out_valid_q || out_ready_i)) begin
      cmd_o.out_load = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      band_q      <= '0;
      chan_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cmd_o.start) begin
            state_q <= S_RUN;
            step_q  <= '0;
            band_q  <= '0;
            chan_q  <= 1'b0;
          end
        end
        S_RUN: begin
          if (step_q == STEP_LAST) begin
            step_q <= '0;
            if (last_band) begin
              band_q <= '0;
              if (chan_q) begin
                state_q <= S_FIN;
              end else begin
                chan_q <= 1'b1;
              end
            end else begin
              band_q <= band_q + BAND_W'(1);
            end
          end else begin
            step_q <= step_q + STEP_W'(1);
          end
        end
        S_FIN: begin
          if (cmd_o.out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= STEP_LAST) else $error("step counter out of range");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten while still held");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_q) else $error("loaded result not shown");

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> (state_q == S_RUN) && (step_q == '0) && (band_q == '0) && !chan_q)
    else $error("filter word did not start at band zero");

endmodule

FILE: rtl/sbeq_dp.sv
// ----------------------------------------------------------------------------
// sbeq_dp
// Datapath: coefficient and delay stores, one shared split multiplier,
// rounding, accumulation and the result registers.
// ----------------------------------------------------------------------------
module sbeq_dp #(
  parameter int unsigned BAND_COUNT = sbeq_pkg::DEF_BAND_COUNT,
  parameter int unsigned BAND_W     = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  sbeq_pkg::cmd_t                         cmd_i,
  input  logic [BAND_W-1:0]                      band_sel_i,
  input  logic                                   chan_i,
  input  logic [3:0]                             band_i,
  input  logic [2:0]                             coefficient_index_i,
  input  logic signed [31:0]                     coefficient_value_i,
  input  logic signed [sbeq_pkg::SAMPLE_W-1:0]   left_in_i,
  input  logic signed [sbeq_pkg::SAMPLE_W-1:0]   right_in_i,
  output logic signed [sbeq_pkg::SAMPLE_W-1:0]   left_out_o,
  output logic signed [sbeq_pkg::SAMPLE_W-1:0]   right_out_o
);
  import sbeq_pkg::*;

  localparam int unsigned CDEPTH = BAND_COUNT * COEF_SLOTS;
  localparam int unsigned CA_W   = $clog2(CDEPTH);
  localparam int unsigned DA_W   = BAND_W + 1;
  localparam int unsigned DDEPTH = 1 << DA_W;

  // coefficient store
  logic signed [COEF_W-1:0]  cmem [CDEPTH];
  logic [CDEPTH-1:0]         cval_q;
  logic [CA_W-1:0]           cwa;
  logic [CA_W-1:0]           cra;
  logic                      cwe;
  logic signed [COEF_W-1:0]  coef_q;

  assign cwe = cmd_i.coef_wr && (32'(band_i) < BAND_COUNT) && (coefficient_index_i <= COEF_A2);
  assign cwa = CA_W'(32'(band_i) * COEF_SLOTS + 32'(coefficient_index_i));
  assign cra = CA_W'(32'(band_sel_i) * COEF_SLOTS + 32'(cmd_i.coef_idx));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cval_q <= '0;
    end else if (cwe) begin
      cval_q[cwa] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cwe) begin
      cmem[cwa] <= coefficient_value_i;
    end
    if (cmd_i.coef_rd) begin
      if (cval_q[cra]) begin
        coef_q <= cmem[cra];
      end else begin
        coef_q <= (cmd_i.coef_idx == COEF_B0) ? COEF_ONE : '0;
      end
    end
  end

  // delay store, one row {s1, s2} per channel and band
  logic [2*STATE_W-1:0]      dmem [DDEPTH];
  logic [DDEPTH-1:0]         dval_q;
  logic [DA_W-1:0]           da;
  logic                      dwe;
  logic signed [STATE_W-1:0] s1_q;
  logic signed [STATE_W-1:0] s2_q;
  logic signed [STATE_W-1:0] s1_new;
  logic signed [STATE_W-1:0] s2_new;

  assign da  = {chan_i, band_sel_i};
  assign dwe = (cmd_i.acc == ACC_WB);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dval_q <= '0;
    end else if (cmd_i.clear) begin
      dval_q <= '0;
    end else if (dwe) begin
      dval_q[da] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dwe) begin
      dmem[da] <= {s1_new, s2_new};
    end
    if (cmd_i.dly_rd) begin
      if (dval_q[da]) begin
        {s1_q, s2_q} <= dmem[da];
      end else begin
        s1_q <= '0;
        s2_q <= '0;
      end
    end
  end

  // shared multiplier, signal operand split into two halves
  logic signed [STATE_W-1:0] x_q;
  logic signed [STATE_W-1:0] y_q;
  logic signed [STATE_W-1:0] src;
  logic signed [OPND_W-1:0]  opnd;
  logic signed [PROD_W-1:0]  m_q;
  logic signed [PROD_W-1:0]  mlo_q;
  logic signed [FULL_W-1:0]  full;
  logic signed [RND_W-1:0]   r_q;

  assign src  = cmd_i.mul_y ? y_q : x_q;
  assign opnd = cmd_i.mul_hi ? {src[STATE_W-1], src[STATE_W-1:HALF_W]}
                             : {1'b0, src[HALF_W-1:0]};
  assign full = (FULL_W'(m_q) <<< HALF_W) + FULL_W'(mlo_q)
              + (FULL_W'(1) <<< (COEF_FRAC - 1));

  always_ff @(posedge clk_i) begin
    m_q   <= coef_q * opnd;
    mlo_q <= m_q;
    r_q   <= full[FULL_W-1:COEF_FRAC];
  end

  // accumulation
  logic signed [ACC_W-1:0]    acc1_q;
  logic signed [ACC_W-1:0]    acc2_q;
  logic signed [SAMPLE_W-1:0] rsamp_q;
  logic signed [SAMPLE_W-1:0] lres_q;
  logic signed [SAMPLE_W-1:0] lout_q;
  logic signed [SAMPLE_W-1:0] rout_q;

  assign s1_new = sat_state(acc1_q);
  assign s2_new = sat_state(acc2_q - ACC_W'(r_q));

  always_ff @(posedge clk_i) begin
    case (cmd_i.acc)
      ACC_Y:   y_q    <= sat_state(ACC_W'(r_q) + ACC_W'(s1_q));
      ACC_S1:  acc1_q <= ACC_W'(r_q) + ACC_W'(s2_q);
      ACC_S2:  acc2_q <= ACC_W'(r_q);
      ACC_S1F: acc1_q <= acc1_q - ACC_W'(r_q);
      ACC_WB:  x_q    <= cmd_i.chan_sw
                         ? {{(STATE_W-SAMPLE_W-GUARD_W){rsamp_q[SAMPLE_W-1]}}, rsamp_q,
                            {GUARD_W{1'b0}}}
                         : y_q;
      default: acc2_q <= acc2_q;
    endcase
    if (cmd_i.start) begin
      x_q     <= {{(STATE_W-SAMPLE_W-GUARD_W){left_in_i[SAMPLE_W-1]}}, left_in_i,
                  {GUARD_W{1'b0}}};
      rsamp_q <= right_in_i;
    end
    if (cmd_i.chan_sw) begin
      lres_q <= finish_sample(y_q);
    end
    if (cmd_i.out_load) begin
      lout_q <= lres_q;
      rout_q <= finish_sample(y_q);
    end
  end

  assign left_out_o  = lout_q;
  assign right_out_o = rout_q;

endmodule

FILE: rtl/stereo_cascaded_biquad_eq.sv
// ----------------------------------------------------------------------------
// stereo_cascaded_biquad_eq
// Stereo cascaded-biquad equalizer, transposed direct form II per band.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o) takes one word per handshake:
// action selects filter a sample pair, load one coefficient, or clear all
// delay state. Loads and clears give no result.
// A filter word runs both channels through all bands on one shared
// 32x21 multiplier, each product in two halves; in_ready_o is low from
// accept until the result is written to the output register, so a new
// word is taken only once the filter word before it is finished.
// Results leave on the output channel (out_valid_o / out_ready_i) from an
// output register; new words are taken while a result waits. If the
// receiver stalls, a finished word waits before its result is written.
// Reset makes every band flat (b0 one) and zeroes all delay state.
// ----------------------------------------------------------------------------
module stereo_cascaded_biquad_eq #(
  parameter int unsigned BAND_COUNT = sbeq_pkg::DEF_BAND_COUNT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [1:0]                           action_i,
  input  logic [3:0]                           band_i,
  input  logic [2:0]                           coefficient_index_i,
  input  logic signed [31:0]                   coefficient_value_i,
  input  logic signed [sbeq_pkg::SAMPLE_W-1:0] left_in_i,
  input  logic signed [sbeq_pkg::SAMPLE_W-1:0] right_in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [sbeq_pkg::SAMPLE_W-1:0] left_out_o,
  output logic signed [sbeq_pkg::SAMPLE_W-1:0] right_out_o
);
  import sbeq_pkg::*;

  localparam int unsigned BAND_W = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;

  cmd_t              cmd;
  logic [BAND_W-1:0] band_sel;
  logic              chan;

  sbeq_ctrl #(
    .BAND_COUNT(BAND_COUNT),
    .BAND_W    (BAND_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd),
    .band_o     (band_sel),
    .chan_o     (chan)
  );

  sbeq_dp #(
    .BAND_COUNT(BAND_COUNT),
    .BAND_W    (BAND_W)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .band_sel_i         (band_sel),
    .chan_i             (chan),
    .band_i             (band_i),
    .coefficient_index_i(coefficient_index_i),
    .coefficient_value_i(coefficient_value_i),
    .left_in_i          (left_in_i),
    .right_in_i         (right_in_i),
    .left_out_o         (left_out_o),
    .right_out_o        (right_out_o)
  );

endmodule

FILE: dv/sbeq_checker.sv
// ----------------------------------------------------------------------------
// sbeq_checker
// Watches both channels of the equalizer, models the biquad cascade for
// each accepted filter word and compares every result against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbeq_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_ready_i,
  input  logic [1:0]                           action_i,
  input  logic [3:0]                           band_i,
  input  logic [2:0]                           coefficient_index_i,
  input  logic signed [31:0]                   coefficient_value_i,
  input  logic signed [sbeq_pkg::SAMPLE_W-1:0] left_in_i,
  input  logic signed [sbeq_pkg::SAMPLE_W-1:0] right_in_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_ready_i,
  input  logic signed [sbeq_pkg::SAMPLE_W-1:0] left_out_i,
  input  logic signed [sbeq_pkg::SAMPLE_W-1:0] right_out_i,
  output int                                   fail_count_o,
  output int                                   pending_o,
  output int                                   checked_o,
  output int                                   loads_o,
  output int                                   clears_o
);
  import sbeq_pkg::*;

  localparam int BANDS = DEF_BAND_COUNT;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } pair_t;

  logic signed [COEF_W-1:0]  coef_q [BANDS][COEF_SLOTS];
  logic signed [STATE_W-1:0] delay_q [2][BANDS][2];
  pair_t                     pair_q [$];

  function automatic logic signed [79:0] mul_rnd(input logic signed [COEF_W-1:0] c,
                                                 input logic signed [STATE_W-1:0] x);
    logic signed [79:0] p;
    p = 80'(c) * 80'(x);
    return (p + (80'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
  endfunction

  function automatic logic signed [STATE_W-1:0] clip_state(input logic signed [79:0] v);
    logic signed [79:0] hi;
    logic signed [79:0] lo;
    hi = (80'sd1 <<< (STATE_W - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi[STATE_W-1:0];
    if (v < lo) return lo[STATE_W-1:0];
    return v[STATE_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] equalize(input int ch,
                                                          input logic signed [SAMPLE_W-1:0] s);
    logic signed [STATE_W-1:0] x;
    logic signed [STATE_W-1:0] y;
    logic signed [79:0]        t;
    x = STATE_W'(s) <<< GUARD_W;
    for (int b = 0; b < BANDS; b++) begin
      y = clip_state(mul_rnd(coef_q[b][COEF_B0], x) + 80'(delay_q[ch][b][0]));
      delay_q[ch][b][0] = clip_state(mul_rnd(coef_q[b][COEF_B1], x)
                                     - mul_rnd(coef_q[b][COEF_A1], y)
                                     + 80'(delay_q[ch][b][1]));
      delay_q[ch][b][1] = clip_state(mul_rnd(coef_q[b][COEF_B2], x)
                                     - mul_rnd(coef_q[b][COEF_A2], y));
      x = y;
    end
    t = (80'(x) + 80'sd128) >>> GUARD_W;
    if (t > 80'sd8388607) return 24'sh7fffff;
    if (t < -80'sd8388608) return 24'sh800000;
    return t[SAMPLE_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pair_t want;
    pair_t got;
    if (!rst_ni) begin
      for (int b = 0; b < BANDS; b++) begin
        for (int k = 0; k < COEF_SLOTS; k++) coef_q[b][k] = (k == 0) ? COEF_ONE : '0;
        for (int c = 0; c < 2; c++) begin
          delay_q[c][b][0] = '0;
          delay_q[c][b][1] = '0;
        end
      end
      pair_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
      loads_o      <= 0;
      clears_o     <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        case (action_i)
          ACT_FILTER: begin
            want.left  = equalize(0, left_in_i);
            want.right = equalize(1, right_in_i);
            pair_q.push_back(want);
          end
          ACT_LOAD: begin
            loads_o <= loads_o + 1;
            if (band_i < BANDS && coefficient_index_i < COEF_SLOTS)
              coef_q[band_i][coefficient_index_i] = coefficient_value_i;
          end
          ACT_CLEAR: begin
            clears_o <= clears_o + 1;
            for (int b = 0; b < BANDS; b++) begin
              for (int c = 0; c < 2; c++) begin
                delay_q[c][b][0] = '0;
                delay_q[c][b][1] = '0;
              end
            end
          end
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got.left  = left_out_i;
        got.right = right_out_i;
        if (pair_q.size() == 0) begin
          $error("result word with nothing expected: left %0d right %0d", got.left, got.right);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = pair_q.pop_front();
          checked_o <= checked_o + 1;
          if (want.left !== got.left || want.right !== got.right) begin
            if (want.left !== got.left)
              $error("left_out expected %0d actual %0d", want.left, got.left);
            if (want.right !== got.right)
              $error("right_out expected %0d actual %0d", want.right, got.right);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= pair_q.size();
    end
  end

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the stereo biquad equalizer: directed corner
// words, then random loads, clears and sample pairs under several idle phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import sbeq_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 3000;

  localparam logic [1:0] ACT_SPARE = 2'd3;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [1:0]                 action = '0;
  logic [3:0]                 band = '0;
  logic [2:0]                 coef_idx = '0;
  logic signed [31:0]         coef_val = '0;
  logic signed [SAMPLE_W-1:0] left_in = '0;
  logic signed [SAMPLE_W-1:0] right_in = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;

  int fail_count, pending, checked, loads, clears;
  int phase = 0;
  int sent = 0;
  int idle_cnt = 0;
  bit hold_req = 1'b0;

  stereo_cascaded_biquad_eq dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .action_i(action), .band_i(band), .coefficient_index_i(coef_idx),
    .coefficient_value_i(coef_val), .left_in_i(left_in), .right_in_i(right_in),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .left_out_o(left_out), .right_out_o(right_out)
  );

  sbeq_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .action_i(action), .band_i(band), .coefficient_index_i(coef_idx),
    .coefficient_value_i(coef_val), .left_in_i(left_in), .right_in_i(right_in),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .left_out_i(left_out), .right_out_i(right_out),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked),
    .loads_o(loads), .clears_o(clears)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // receiver: random stalls per phase, plus one long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      case (phase)
        2:       out_ready <= ($urandom_range(99) >= 87);
        3:       out_ready <= ($urandom_range(99) >= 33);
        default: out_ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("** stereo_cascaded_biquad_eq: FAILED **");
      $finish;
    end
  end

  task automatic send_word(input logic [1:0] act, input logic [3:0] bnd,
                           input logic [2:0] idx, input logic [31:0] val,
                           input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r);
    int pct;
    pct = (phase == 1) ? 87 : (phase == 3) ? 33 : 0;
    while ($urandom_range(99) < pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    band     <= bnd;
    coef_idx <= idx;
    coef_val <= val;
    left_in  <= l;
    right_in <= r;
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
    sent++;
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r);
    send_word(ACT_FILTER, 4'($urandom), 3'($urandom), $urandom, l, r);
  endtask

  task automatic load_coef(input logic [3:0] bnd, input logic [2:0] idx, input logic [31:0] val);
    send_word(ACT_LOAD, bnd, idx, val, SAMPLE_W'($urandom), SAMPLE_W'($urandom));
  endtask

  task automatic make_flat();
    for (int b = 0; b < DEF_BAND_COUNT; b++) begin
      load_coef(4'(b), COEF_B0, COEF_ONE);
      for (int k = 1; k < COEF_SLOTS; k++) load_coef(4'(b), 3'(k), '0);
    end
  endtask

  function automatic logic [31:0] mild_coef(input logic [2:0] idx);
    if ($urandom_range(99) < 20) return $urandom;
    if (idx == COEF_B0) return COEF_ONE + $signed($urandom_range(1 << 28)) - (1 << 27);
    return $signed($urandom_range(1 << 27)) - (1 << 26);
  endfunction

  // stop offering and wait until every expected result has left
  task automatic drain();
    in_valid <= 1'b0;
    forever begin
      @(negedge clk);
      if (pending == 0 && !out_valid) break;
    end
    @(posedge clk);
  endtask

  initial begin
    int r;
    logic [2:0] idx;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners on flat bands
    send_sample(24'h7fffff, 24'h800000);
    send_sample(24'h800000, 24'h7fffff);
    send_sample(24'h000000, 24'hffffff);
    // gain on the first band drives saturation
    load_coef(4'd0, COEF_B0, 32'h7fffffff);
    send_sample(24'h7fffff, 24'h800000);
    load_coef(4'd15, COEF_B0, 32'h80000000);
    send_sample(24'h400000, 24'hc00000);
    load_coef(4'd3, COEF_B1, 32'h10000000);
    load_coef(4'd3, COEF_B2, 32'hf0000000);
    load_coef(4'd3, COEF_A1, 32'h08000000);
    load_coef(4'd3, COEF_A2, 32'h04000000);
    send_sample(24'h123456, 24'hedcba9);
    send_sample(24'h000001, 24'hfffffe);
    // ignored indexes and the spare action
    load_coef(4'd5, 3'd5, 32'h7fffffff);
    load_coef(4'd6, 3'd6, 32'h80000000);
    load_coef(4'd7, 3'd7, 32'h55555555);
    send_word(ACT_SPARE, 4'hf, 3'd7, 32'hffffffff, 24'hffffff, 24'hffffff);
    send_sample(24'h0abcde, 24'hf54321);
    send_word(ACT_CLEAR, 4'hf, 3'd7, 32'hffffffff, 24'hffffff, 24'hffffff);
    send_sample(24'h7fffff, 24'h7fffff);
    send_sample(24'h800000, 24'h800000);
    drain();

    for (phase = 0; phase < 4; phase++) begin
      make_flat();
      send_word(ACT_CLEAR, '0, '0, '0, '0, '0);
      for (int n = 0; n < 240; n++) begin
        if (phase == 2 && n == 100) hold_req = 1'b1;
        if (phase == 1 && n == 120) drain();
        r = $urandom_range(99);
        if (r < 70) begin
          if ($urandom_range(3) == 0)
            send_sample(SAMPLE_W'($signed($urandom_range(4095)) - 2048),
                        SAMPLE_W'($signed($urandom_range(4095)) - 2048));
          else
            send_sample(SAMPLE_W'($urandom), SAMPLE_W'($urandom));
        end else if (r < 90) begin
          idx = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
          load_coef(4'($urandom), idx, mild_coef(idx));
        end else if (r < 96) begin
          send_word(ACT_CLEAR, 4'($urandom), 3'($urandom), $urandom,
                    SAMPLE_W'($urandom), SAMPLE_W'($urandom));
        end else begin
          send_word(ACT_SPARE, 4'($urandom), 3'($urandom), $urandom,
                    SAMPLE_W'($urandom), SAMPLE_W'($urandom));
        end
      end
    end
    phase = 0;
    drain();
    repeat (500) @(posedge clk);

    $display("sent %0d words: %0d results checked, %0d loads, %0d clears over four idle phases",
             sent, checked, loads, clears);
    if (fail_count == 0 && pending == 0) begin
      $display("** stereo_cascaded_biquad_eq: PASSED **");
    end else begin
      $display("** stereo_cascaded_biquad_eq: FAILED **");
    end
    $finish;
  end

endmodule
